/* rtl/core/cbd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cbd_pkg;

  localparam int SIZE_BITS_DEF = 31;

  localparam logic       MODE_STREAM  = 1'b0;
  localparam logic       MODE_RESTART = 1'b1;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;

  localparam logic [1:0] TRAILER_SKIP = 2'd2;

  typedef enum logic [2:0] {
    PH_SIZE  = 3'd0,
    PH_SKIP1 = 3'd1,
    PH_DATA  = 3'd2,
    PH_SKIP2 = 3'd3,
    PH_HALT  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    PS_START  = 3'd0,
    PS_SIGNED = 3'd1,
    PS_ZERO   = 3'd2,
    PS_PREFIX = 3'd3,
    PS_DIGITS = 3'd4,
    PS_DONE   = 3'd5
  } pstep_t;

  typedef struct packed {
    pstep_t step;
    logic   negative;
  } parse_ctl_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] in_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic [31:0] byte_total;
  } out_t;

endpackage

`default_nettype wire

/* rtl/core/cbd_size_parse.sv */
`timescale 1ns / 1ps
`default_nettype none

module cbd_size_parse #(
  parameter int SIZE_BITS = cbd_pkg::SIZE_BITS_DEF
) (
  input  wire cbd_pkg::parse_ctl_t ctl,
  input  wire [SIZE_BITS-1:0]      value,
  input  wire [7:0]                ch,
  output cbd_pkg::parse_ctl_t      ctl_next,
  output logic [SIZE_BITS-1:0]     value_next
);
  import cbd_pkg::*;

  logic                 is_dec;
  logic                 is_upper;
  logic                 is_lower;
  logic                 is_hex;
  logic                 is_blank;
  logic                 is_sign;
  logic                 is_x;
  logic [7:0]           diff;
  logic [3:0]           digit;
  logic [SIZE_BITS-1:0] added;

  always_comb begin
    is_dec   = (ch >= CH_ZERO) && (ch <= CH_NINE);
    is_upper = (ch >= CH_UA) && (ch <= CH_UF);
    is_lower = (ch >= CH_LA) && (ch <= CH_LF_HEX);
    is_hex   = is_dec || is_upper || is_lower;
    is_blank = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_VT) || (ch == CH_FF);
    is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
    is_x     = (ch == CH_UX) || (ch == CH_LX);
    if (is_dec) begin
      diff = ch - CH_ZERO;
    end else if (is_upper) begin
      diff = ch - CH_UA + 8'd10;
    end else begin
      diff = ch - CH_LA + 8'd10;
    end
    digit = diff[3:0];
    // saturate when the top nibble would shift out
    if (value[SIZE_BITS-1 -: 4] != 4'd0) begin
      added = {SIZE_BITS{1'b1}};
    end else begin
      added = {value[SIZE_BITS-5:0], digit};
    end
  end

  always_comb begin
    ctl_next   = ctl;
    value_next = value;
    case (ctl.step)
      PS_START, PS_SIGNED: begin
        if ((ctl.step == PS_START) && is_blank) begin
          ctl_next = ctl;
        end else if ((ctl.step == PS_START) && is_sign) begin
          ctl_next.negative = (ch == CH_MINUS);
          ctl_next.step     = PS_SIGNED;
        end else if (ch == CH_ZERO) begin
          ctl_next.step = PS_ZERO;
        end else if (is_hex) begin
          value_next    = added;
          ctl_next.step = PS_DIGITS;
        end else begin
          ctl_next.step = PS_DONE;
        end
      end
      PS_ZERO: begin
        if (is_x) begin
          ctl_next.step = PS_PREFIX;
        end else if (is_hex) begin
          value_next    = added;
          ctl_next.step = PS_DIGITS;
        end else begin
          ctl_next.step = PS_DONE;
        end
      end
      PS_PREFIX, PS_DIGITS: begin
        if (is_hex) begin
          value_next    = added;
          ctl_next.step = PS_DIGITS;
        end else begin
          ctl_next.step = PS_DONE;
        end
      end
      default: begin
        ctl_next = ctl;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/chunked_body_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none

// Chunked body decoder.
// item channel: one beat per received body byte (mode stream) or a restart
//   beat (mode restart) that returns the decoder to the start of a new body.
// result channel: one beat per payload byte, plus one end beat (body closed
//   by a zero size) or one error beat (negative size), each with the running
//   payload byte total. Size lines, the byte after each size line and the two
//   bytes after each chunk give no beat.
// Output: a result beat is registered; it is on result in the cycle after its item
//   beat is taken when the output register is free, else it waits in the skid register.
// Throughput: one item per cycle while item_stall is low.
// Stall: results queue in an output register plus one skid register; item_stall
//   goes high only while the skid register holds a beat, so the item side keeps
//   moving while one result waits.
// Reset: rst clears the decoder to the start of a size line, with a zero total,
//   and empties the output register and skid register.
// After an end or error beat, stream bytes are dropped until a restart beat.
module chunked_body_decoder #(
  parameter int SIZE_BITS = cbd_pkg::SIZE_BITS_DEF
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                item_valid,
  output logic               item_stall,
  input  wire cbd_pkg::in_t  item,
  output logic               result_valid,
  input  wire                result_stall,
  output cbd_pkg::out_t      result
);
  import cbd_pkg::*;

  phase_t               phase;
  phase_t               phase_next;
  parse_ctl_t           pctl;
  parse_ctl_t           pctl_next;
  parse_ctl_t           pctl_upd;
  logic [SIZE_BITS-1:0] size_value;
  logic [SIZE_BITS-1:0] size_value_next;
  logic [SIZE_BITS-1:0] size_value_upd;
  logic [SIZE_BITS-1:0] bytes_left;
  logic [SIZE_BITS-1:0] bytes_left_next;
  logic [SIZE_BITS-1:0] bytes_dec;
  logic [1:0]           skip_left;
  logic [1:0]           skip_left_next;
  logic [1:0]           skip_dec;
  logic [31:0]          running_total;
  logic [31:0]          running_total_next;
  logic [31:0]          total_inc;

  logic                 accept;
  logic                 res_valid;
  out_t                 res;
  logic                 pop;
  logic                 skid_valid;
  out_t                 skid;

  cbd_size_parse #(
    .SIZE_BITS(SIZE_BITS)
  ) u_parse (
    .ctl       (pctl),
    .value     (size_value),
    .ch        (item.in_byte),
    .ctl_next  (pctl_upd),
    .value_next(size_value_upd)
  );

  assign item_stall = skid_valid;
  assign accept     = item_valid && !item_stall;
  assign pop        = result_valid && !result_stall;

  always_comb begin
    phase_next         = phase;
    pctl_next          = pctl;
    size_value_next    = size_value;
    bytes_left_next    = bytes_left;
    skip_left_next     = skip_left;
    running_total_next = running_total;
    res_valid          = 1'b0;
    res.out_kind       = KIND_DATA;
    res.out_byte       = 8'd0;
    res.byte_total     = running_total;
    total_inc = (running_total == 32'hffff_ffff) ? running_total : running_total + 32'd1;
    bytes_dec = (bytes_left != '0) ? bytes_left - SIZE_BITS'(1) : bytes_left;
    skip_dec  = (skip_left != 2'd0) ? skip_left - 2'd1 : skip_left;
    if (accept) begin
      if (item.mode == MODE_RESTART) begin
        phase_next         = PH_SIZE;
        pctl_next.step     = PS_START;
        pctl_next.negative = 1'b0;
        size_value_next    = '0;
        bytes_left_next    = '0;
        skip_left_next     = 2'd0;
        running_total_next = 32'd0;
      end else begin
        case (phase)
          PH_SIZE: begin
            if ((item.in_byte != CH_CR) && (item.in_byte != CH_LF)) begin
              pctl_next       = pctl_upd;
              size_value_next = size_value_upd;
            end else if (size_value == '0) begin
              phase_next   = PH_HALT;
              res_valid    = 1'b1;
              res.out_kind = KIND_END;
            end else if (pctl.negative) begin
              phase_next   = PH_HALT;
              res_valid    = 1'b1;
              res.out_kind = KIND_ERROR;
            end else begin
              bytes_left_next = size_value;
              phase_next      = PH_SKIP1;
            end
          end
          PH_SKIP1: begin
            phase_next = PH_DATA;
          end
          PH_DATA: begin
            running_total_next = total_inc;
            bytes_left_next    = bytes_dec;
            if (bytes_dec == '0) begin
              phase_next     = PH_SKIP2;
              skip_left_next = TRAILER_SKIP;
            end
            res_valid      = 1'b1;
            res.out_kind   = KIND_DATA;
            res.out_byte   = item.in_byte;
            res.byte_total = total_inc;
          end
          PH_SKIP2: begin
            skip_left_next = skip_dec;
            if (skip_dec == 2'd0) begin
              phase_next         = PH_SIZE;
              pctl_next.step     = PS_START;
              pctl_next.negative = 1'b0;
              size_value_next    = '0;
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SIZE;
      pctl.step     <= PS_START;
      pctl.negative <= 1'b0;
      size_value    <= '0;
      bytes_left    <= '0;
      skip_left     <= 2'd0;
      running_total <= 32'd0;
    end else begin
      phase         <= phase_next;
      pctl          <= pctl_next;
      size_value    <= size_value_next;
      bytes_left    <= bytes_left_next;
      skip_left     <= skip_left_next;
      running_total <= running_total_next;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (!result_valid || pop) begin
      result_valid <= res_valid;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        result <= skid;
      end
    end else if (!result_valid || pop) begin
      result <= res;
    end else if (res_valid) begin
      skid <= res;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry held with empty output register");

  a_data_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (bytes_left != '0))
    else $error("data phase with no bytes left");

  a_skip_only_trailer: assert property (@(posedge clk) disable iff (rst)
    (skip_left != 2'd0) |-> (phase == PH_SKIP2))
    else $error("trailer skip count outside trailer phase");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    ((phase == PH_HALT) && !(accept && (item.mode == MODE_RESTART))) |=> (phase == PH_HALT))
    else $error("left halt without restart");

  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.out_kind == KIND_DATA) || (result.out_kind == KIND_END)
                      || (result.out_kind == KIND_ERROR)))
    else $error("bad result kind");

endmodule

`default_nettype wire
